// ===== src/itx_pkg.sv =====
`default_nettype none

package itx_pkg;

   localparam logic [5:0] OP_ADDI  = 6'd8;
   localparam logic [5:0] OP_ADDIU = 6'd9;
   localparam logic [5:0] OP_SLTI  = 6'd10;
   localparam logic [5:0] OP_SLTIU = 6'd11;
   localparam logic [5:0] OP_ANDI  = 6'd12;
   localparam logic [5:0] OP_ORI   = 6'd13;
   localparam logic [5:0] OP_XORI  = 6'd14;
   localparam logic [5:0] OP_LUI   = 6'd15;
   localparam logic [5:0] OP_LB    = 6'd32;
   localparam logic [5:0] OP_LW    = 6'd35;
   localparam logic [5:0] OP_LBU   = 6'd36;
   localparam logic [5:0] OP_SB    = 6'd40;
   localparam logic [5:0] OP_SW    = 6'd43;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OVF  = 2'd1;
   localparam logic [1:0] STATUS_ADDR = 2'd2;
   localparam logic [1:0] STATUS_BAD  = 2'd3;

   localparam logic [31:0] UPPER_MASK = 32'hFFFF_0000;

   typedef enum logic [2:0] {
      KIND_ALU,
      KIND_LB,
      KIND_LBU,
      KIND_LW,
      KIND_SB,
      KIND_SW
   } itx_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_MEM
   } itx_state_type;

   typedef struct packed {
      logic [5:0]  opcode;
      logic [31:0] source_value;
      logic [31:0] target_value;
      logic [15:0] immediate;
   } itx_req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        writes_register;
      logic [1:0]  status;
   } itx_rsp_type;

   typedef struct packed {
      itx_kind_type kind;
      logic [31:0]  alu_value;
      logic         alu_write;
      logic [1:0]   status;
      logic [31:0]  addr;
      logic [31:0]  store_data;
   } itx_dec_type;

endpackage

`default_nettype wire

// ===== src/itx_ram.sv =====
`default_nettype none

module itx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/itx_decode.sv =====
`default_nettype none

module itx_decode #(
   parameter int MEM_BYTES = 65536
) (
   input  wire itx_pkg::itx_req_type req,
   output itx_pkg::itx_dec_type      dec
);

   import itx_pkg::*;

   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] sum;
   logic        in_range;
   logic        aligned;

   assign simm     = {{16{req.immediate[15]}}, req.immediate};
   assign zimm     = {16'd0, req.immediate};
   assign sum      = req.source_value + simm;
   assign in_range = sum < 32'(MEM_BYTES);
   assign aligned  = sum[1:0] == 2'd0;

   always_comb begin
      dec            = '0;
      dec.kind       = KIND_ALU;
      dec.status     = STATUS_OK;
      dec.addr       = sum;
      dec.store_data = req.target_value;
      unique case (req.opcode) inside
         OP_ADDI: begin
            if ((~(req.source_value[31] ^ simm[31])) & (req.source_value[31] ^ sum[31])) begin
               dec.status = STATUS_OVF;
            end else begin
               dec.alu_value = sum;
               dec.alu_write = 1'b1;
            end
         end
         OP_ADDIU: begin
            dec.alu_value = sum;
            dec.alu_write = 1'b1;
         end
         OP_SLTI: begin
            dec.alu_value = {31'd0, $signed(req.source_value) < $signed(simm)};
            dec.alu_write = 1'b1;
         end
         OP_SLTIU: begin
            dec.alu_value = {31'd0, req.source_value < simm};
            dec.alu_write = 1'b1;
         end
         OP_ANDI: begin
            dec.alu_value = req.source_value & zimm;
            dec.alu_write = 1'b1;
         end
         OP_ORI: begin
            dec.alu_value = req.source_value | zimm;
            dec.alu_write = 1'b1;
         end
         OP_XORI: begin
            dec.alu_value = req.source_value ^ zimm;
            dec.alu_write = 1'b1;
         end
         OP_LUI: begin
            dec.alu_value = {req.immediate, 16'd0} & UPPER_MASK;
            dec.alu_write = 1'b1;
         end
         OP_LB, OP_LBU, OP_SB: begin
            if (!in_range) begin
               dec.status = STATUS_ADDR;
            end else if (req.opcode == OP_LB) begin
               dec.kind = KIND_LB;
            end else if (req.opcode == OP_LBU) begin
               dec.kind = KIND_LBU;
            end else begin
               dec.kind = KIND_SB;
            end
         end
         OP_LW, OP_SW: begin
            if (!in_range || !aligned) begin
               dec.status = STATUS_ADDR;
            end else if (req.opcode == OP_LW) begin
               dec.kind = KIND_LW;
            end else begin
               dec.kind = KIND_SW;
            end
         end
         default: begin
            dec.status = STATUS_BAD;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/mips_itype_execute_unit.sv =====
`default_nettype none

// Executes one MIPS I-type instruction per item (ALU immediates, LB/LBU/LW,
// SB/SW) against a big-endian byte-addressed data memory of MEM_BYTES bytes
// held as 32-bit words in a single-port-read synchronous RAM. The accept
// cycle issues the RAM read; then, in ST_MEM once the output register is
// free, the unit merges the read word (loads, and the read-modify-write of
// SB) and writes the result into the output register. The input side accepts
// the next item while a result still waits in that register, but takes no
// new item while the current one is in ST_MEM. Memory contents are undefined
// after reset; a load from a byte never stored returns an undefined value.

module mips_itype_execute_unit #(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire itx_pkg::itx_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output itx_pkg::itx_rsp_type      rsp_data
);

   import itx_pkg::*;

   localparam int WORDS = (MEM_BYTES + 3) / 4;
   localparam int AW    = $clog2(WORDS);

   itx_state_type state_ff, state_in;
   itx_dec_type   dec;
   itx_dec_type   ctrl_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   itx_rsp_type   rsp_data_ff, rsp_data_in;
   logic          req_fire;
   logic          out_free;
   logic          finish;
   logic [31:0]   rd_word;
   logic [7:0]    rd_byte;
   logic [31:0]   merged;
   logic          wr_en;
   logic [31:0]   wr_word;

   itx_decode #(.MEM_BYTES(MEM_BYTES)) u_decode (
      .req (req_data),
      .dec (dec)
   );

   itx_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ctrl_ff.addr[AW+1:2]),
      .wr_data (wr_word),
      .rd_en   (req_fire),
      .rd_addr (dec.addr[AW+1:2]),
      .rd_data (rd_word)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MEM;
            end
         end
         ST_MEM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MEM: begin
            finish = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctrl_ff.addr[1:0])
         2'd0:    rd_byte = rd_word[31:24];
         2'd1:    rd_byte = rd_word[23:16];
         2'd2:    rd_byte = rd_word[15:8];
         default: rd_byte = rd_word[7:0];
      endcase
      merged = rd_word;
      case (ctrl_ff.addr[1:0])
         2'd0:    merged[31:24] = ctrl_ff.store_data[7:0];
         2'd1:    merged[23:16] = ctrl_ff.store_data[7:0];
         2'd2:    merged[15:8]  = ctrl_ff.store_data[7:0];
         default: merged[7:0]   = ctrl_ff.store_data[7:0];
      endcase
   end

   assign wr_en   = finish && (ctrl_ff.kind == KIND_SB || ctrl_ff.kind == KIND_SW);
   assign wr_word = (ctrl_ff.kind == KIND_SW) ? ctrl_ff.store_data : merged;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = ctrl_ff.status;
         rsp_data_in.result_value    = '0;
         rsp_data_in.writes_register = 1'b0;
         case (ctrl_ff.kind)
            KIND_ALU: begin
               rsp_data_in.result_value    = ctrl_ff.alu_value;
               rsp_data_in.writes_register = ctrl_ff.alu_write;
            end
            KIND_LB: begin
               rsp_data_in.result_value    = {{24{rd_byte[7]}}, rd_byte};
               rsp_data_in.writes_register = 1'b1;
            end
            KIND_LBU: begin
               rsp_data_in.result_value    = {24'd0, rd_byte};
               rsp_data_in.writes_register = 1'b1;
            end
            KIND_LW: begin
               rsp_data_in.result_value    = rd_word;
               rsp_data_in.writes_register = 1'b1;
            end
            default: begin
               rsp_data_in.writes_register = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ctrl_ff <= dec;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
